// File: rtl/core/csp_pkg.sv
`default_nettype none

package csp_pkg;

  // default geometry and number format
  localparam int FRAME_BYTES_DEF = 8;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int MAX_SIGNAL_BITS = 32;
  localparam int BITS_PER_BYTE   = 8;
  localparam int PAYLOAD_BITS    = 64;

  // packed stream widths
  localparam int S_TDATA_W = 144;
  localparam int M_TDATA_W = 104;

  // command codes carried in tuser
  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  // byte order codes
  localparam logic BO_MOTOROLA = 1'b0;
  localparam logic BO_INTEL    = 1'b1;

endpackage

`default_nettype wire

// File: rtl/core/can_signal_packer_top.sv
`default_nettype none

// can signal packer: builds a CAN frame payload from scaled DBC signals
// slave stream s_axis carries one request per signal or per new frame:
//   tuser selects start (clear payload, latch id and length) or insert
//   insert scales raw = (physical * 2^FRAC_BITS - offset) / factor and
//   ORs the low bits of raw, as many as the signal length, into the
//   payload from the signal's start position
// master stream m_axis returns one result per request with the frame id,
//   length, current payload and the overflow and clamp flags
// sequencing: a start request gives its result in the cycle after acceptance;
//   an insert request runs a negate step, the restoring divider that
//   retires one quotient bit per cycle (FRAC_BITS + 33 steps), a fix step
//   for clamp and overflow, and the bit placer that writes one payload bit
//   per cycle for L bits, L being the saturated signal length (0..32)
// throughput: starts can follow every cycle while m_axis_tready is high;
//   s_axis_tready is low while an insert is in flight
// the result sits in an output register; no new request is accepted while
//   it waits, and a finished insert holds in its last step until the
//   result register is free
// reset clears payload, id and length to zero and drops m_axis_tvalid
module can_signal_packer_top #(
  parameter int FRAME_BYTES = csp_pkg::FRAME_BYTES_DEF,
  parameter int FRAC_BITS   = csp_pkg::FRAC_BITS_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  // message_id[28:0], data_length[32:29], sig_start[38:33],
  // sig_len[44:39], byte_order[45], physical_value[77:46],
  // scale_factor[109:78], scale_offset[141:110], zero fill
  input  wire  [csp_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // command[0]
  input  wire  [0:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  // frame_id[28:0], frame_length[32:29], frame_data[96:33],
  // value_overflow[97], value_clamped[98], zero fill
  output logic [csp_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

  localparam int NUM_W      = 34 + FRAC_BITS;
  localparam int MAG_W      = 33 + FRAC_BITS;
  localparam int STEP_W     = $clog2(MAG_W + 1);
  localparam int FRAME_BITS = FRAME_BYTES * csp_pkg::BITS_PER_BYTE;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEG,
    ST_DIV,
    ST_FIX,
    ST_PLACE,
    ST_DONE
  } state_e;

  // unpacked request fields
  logic        in_cmd;
  logic [28:0] in_id;
  logic [3:0]  in_dlen;
  logic [5:0]  in_start;
  logic [5:0]  in_slen;
  logic        in_bo;
  logic signed [31:0] in_phys;
  logic [31:0] in_factor;
  logic signed [31:0] in_offset;

  assign in_cmd    = s_axis_tuser[0];
  assign in_id     = s_axis_tdata[28:0];
  assign in_dlen   = s_axis_tdata[32:29];
  assign in_start  = s_axis_tdata[38:33];
  assign in_slen   = s_axis_tdata[44:39];
  assign in_bo     = s_axis_tdata[45];
  assign in_phys   = s_axis_tdata[77:46];
  assign in_factor = s_axis_tdata[109:78];
  assign in_offset = s_axis_tdata[141:110];

  // registers
  state_e             state_q, state_d;
  logic [csp_pkg::PAYLOAD_BITS-1:0] payload_q, payload_d;
  logic [28:0]        held_id_q, held_id_d;
  logic [3:0]         held_len_q, held_len_d;
  logic signed [NUM_W-1:0] num_q, num_d;
  logic               neg_q, neg_d;
  logic [31:0]        div_q, div_d;
  logic [31:0]        rem_q, rem_d;
  logic [MAG_W-1:0]   quo_q, quo_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [31:0]        raw_q, raw_d;
  logic               clamp_q, clamp_d;
  logic               ovf_q, ovf_d;
  logic [5:0]         len_q, len_d;
  logic [5:0]         cnt_q, cnt_d;
  logic [6:0]         pos_q, pos_d;
  logic               bo_q, bo_d;
  logic               out_valid_q, out_valid_d;
  logic [28:0]        out_id_q, out_id_d;
  logic [3:0]         out_len_q, out_len_d;
  logic [csp_pkg::PAYLOAD_BITS-1:0] out_data_q, out_data_d;
  logic               out_ovf_q, out_ovf_d;
  logic               out_clamp_q, out_clamp_d;

  logic               accept;
  logic               out_free;
  logic signed [NUM_W-1:0] phys_w;
  logic signed [NUM_W-1:0] off_w;
  logic [32:0]        rem_sh;
  logic               rem_ge;
  logic               fix_clamp;
  logic [MAG_W-1:0]   fix_quo;
  logic [MAG_W-1:0]   hi_mask;
  logic [4:0]         bit_idx;
  logic               cur_bit;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // numerator operands in the Q format
  assign phys_w = NUM_W'(in_phys);
  assign off_w  = NUM_W'(in_offset);

  // one restoring divider step
  assign rem_sh = {rem_q, quo_q[MAG_W-1]};
  assign rem_ge = rem_sh >= {1'b0, div_q};

  // clamp and overflow check on the finished quotient
  assign fix_clamp = neg_q && (quo_q != '0);
  assign fix_quo   = fix_clamp ? '0 : quo_q;
  always_comb begin
    for (int j = 0; j < MAG_W; j++) begin
      hi_mask[j] = (j >= int'(len_q));
    end
  end

  // raw bit picked for the current placement step
  assign bit_idx = (bo_q == csp_pkg::BO_INTEL) ? cnt_q[4:0] : 5'(len_q - 6'd1 - cnt_q);
  assign cur_bit = raw_q[bit_idx];

  // sequencer next state
  always_comb begin
    state_d     = state_q;
    payload_d   = payload_q;
    held_id_d   = held_id_q;
    held_len_d  = held_len_q;
    num_d       = num_q;
    neg_d       = neg_q;
    div_d       = div_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    step_d      = step_q;
    raw_d       = raw_q;
    clamp_d     = clamp_q;
    ovf_d       = ovf_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    bo_d        = bo_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_id_d    = out_id_q;
    out_len_d   = out_len_q;
    out_data_d  = out_data_q;
    out_ovf_d   = out_ovf_q;
    out_clamp_d = out_clamp_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd == csp_pkg::CMD_START) begin
            payload_d   = '0;
            held_id_d   = in_id;
            held_len_d  = (in_dlen > 4'(FRAME_BYTES)) ? 4'(FRAME_BYTES) : in_dlen;
            out_valid_d = 1'b1;
            out_id_d    = in_id;
            out_len_d   = held_len_d;
            out_data_d  = '0;
            out_ovf_d   = 1'b0;
            out_clamp_d = 1'b0;
          end else begin
            num_d   = (phys_w <<< FRAC_BITS) - off_w;
            div_d   = (in_factor == 32'd0) ? 32'd1 : in_factor;
            len_d   = (in_slen > 6'(csp_pkg::MAX_SIGNAL_BITS)) ?
                      6'(csp_pkg::MAX_SIGNAL_BITS) : in_slen;
            bo_d    = in_bo;
            pos_d   = {1'b0, in_start};
            cnt_d   = '0;
            state_d = ST_NEG;
          end
        end
      end
      ST_NEG: begin
        neg_d   = num_q[NUM_W-1];
        quo_d   = num_q[NUM_W-1] ? MAG_W'(-num_q) : MAG_W'(num_q);
        rem_d   = '0;
        step_d  = STEP_W'(MAG_W);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d  = rem_ge ? 32'(rem_sh - {1'b0, div_q}) : rem_sh[31:0];
        quo_d  = {quo_q[MAG_W-2:0], rem_ge};
        step_d = step_q - STEP_W'(1);
        if (step_q == STEP_W'(1)) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX: begin
        clamp_d = fix_clamp;
        raw_d   = fix_quo[31:0];
        ovf_d   = |(fix_quo & hi_mask);
        state_d = (len_q == '0) ? ST_DONE : ST_PLACE;
      end
      ST_PLACE: begin
        // one payload bit per cycle, frames end at FRAME_BITS
        if (cur_bit && (pos_q < 7'(FRAME_BITS))) begin
          payload_d[pos_q[5:0]] = 1'b1;
        end
        if (bo_q == csp_pkg::BO_INTEL) begin
          pos_d = pos_q + 7'd1;
        end else if (pos_q < 7'(csp_pkg::PAYLOAD_BITS)) begin
          // big-endian sawtooth: down within a byte, then to bit 7 of the next
          if (pos_q[2:0] == 3'd0) begin
            pos_d = pos_q + 7'(2 * csp_pkg::BITS_PER_BYTE - 1);
          end else begin
            pos_d = pos_q - 7'd1;
          end
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == len_q - 6'd1) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_id_d    = held_id_q;
          out_len_d   = held_len_q;
          out_data_d  = payload_q;
          out_ovf_d   = ovf_q;
          out_clamp_d = clamp_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // sequencer, frame store, datapath and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      payload_q   <= '0;
      held_id_q   <= '0;
      held_len_q  <= '0;
      num_q       <= '0;
      neg_q       <= 1'b0;
      div_q       <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      step_q      <= '0;
      raw_q       <= '0;
      clamp_q     <= 1'b0;
      ovf_q       <= 1'b0;
      len_q       <= '0;
      cnt_q       <= '0;
      pos_q       <= '0;
      bo_q        <= csp_pkg::BO_MOTOROLA;
      out_valid_q <= 1'b0;
      out_id_q    <= '0;
      out_len_q   <= '0;
      out_data_q  <= '0;
      out_ovf_q   <= 1'b0;
      out_clamp_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      payload_q   <= payload_d;
      held_id_q   <= held_id_d;
      held_len_q  <= held_len_d;
      num_q       <= num_d;
      neg_q       <= neg_d;
      div_q       <= div_d;
      rem_q       <= rem_d;
      quo_q       <= quo_d;
      step_q      <= step_d;
      raw_q       <= raw_d;
      clamp_q     <= clamp_d;
      ovf_q       <= ovf_d;
      len_q       <= len_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      bo_q        <= bo_d;
      out_valid_q <= out_valid_d;
      out_id_q    <= out_id_d;
      out_len_q   <= out_len_d;
      out_data_q  <= out_data_d;
      out_ovf_q   <= out_ovf_d;
      out_clamp_q <= out_clamp_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_clamp_q, out_ovf_q, out_data_q, out_len_q, out_id_q};

  // start request returns an empty frame in the next cycle
  a_start_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_cmd == csp_pkg::CMD_START)) |=>
      (m_axis_tvalid && (m_axis_tdata[96:33] == '0)))
    else $error("start request did not yield an empty frame");

  // divider never runs with an exhausted step count
  a_div_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (step_q != '0))
    else $error("divider step count ran out");

  // a clamped value leaves nothing to place and no overflow
  a_clamp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_PLACE) && clamp_q) |-> ((raw_q == '0) && !ovf_q))
    else $error("clamped value is not zero");

  // big-endian walk stays inside one byte past the payload
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_PLACE) && (bo_q == csp_pkg::BO_MOTOROLA)) |-> (pos_q <= 7'd71))
    else $error("big-endian bit position out of range");

endmodule

`default_nettype wire

// File: sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_BYTES  = csp_pkg::FRAME_BYTES_DEF;
  localparam int FRAC_BITS    = csp_pkg::FRAC_BITS_DEF;
  localparam int MAX_SIGNAL_BITS = csp_pkg::MAX_SIGNAL_BITS;
  localparam int BITS_PER_BYTE   = csp_pkg::BITS_PER_BYTE;
  localparam int PAYLOAD_BITS    = csp_pkg::PAYLOAD_BITS;
  localparam logic CMD_START   = csp_pkg::CMD_START;
  localparam logic CMD_INSERT  = csp_pkg::CMD_INSERT;
  localparam logic BO_MOTOROLA = csp_pkg::BO_MOTOROLA;
  localparam logic BO_INTEL    = csp_pkg::BO_INTEL;
  localparam int CLK_PERIOD   = 10;
  localparam int RANDOM_ITEMS = 950;
  // wait for stray results, longer than the longest insert plus margin
  localparam int DRAIN_CYCLES = 150;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam logic [31:0] Q_ONE = 32'h0001_0000;

  // one request as seen on the slave stream
  typedef struct packed {
    logic              cmd;
    logic [28:0]       msg_id;
    logic [3:0]        data_len;
    logic [5:0]        sig_start;
    logic [5:0]        sig_len;
    logic              byte_order;
    logic signed [31:0] phys;
    logic [31:0]       factor;
    logic signed [31:0] offset;
  } req_t;

  // one frame result as seen on the master stream
  typedef struct packed {
    logic [28:0] id;
    logic [3:0]  len;
    logic [63:0] data;
    logic        ovf;
    logic        clamp;
  } frame_t;

  // directed stimulus row, with a hand-written frame where known
  typedef struct packed {
    req_t   req;
    logic   known;
    frame_t want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [csp_pkg::S_TDATA_W-1:0] s_axis_tdata;
  logic [0:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [csp_pkg::M_TDATA_W-1:0] m_axis_tdata;

  // frame state mirrored by the predictor
  logic [63:0] packed_payload;
  logic [28:0] latched_id;
  logic [3:0]  latched_len;

  frame_t pending_frames[$];
  row_t   directed_rows[$];
  frame_t want_frame;
  frame_t got_frame;

  int mismatches   = 0;
  int cycle_count  = 0;
  int requests_sent = 0;
  int calm_left    = 0;
  int n_starts     = 0;
  int n_inserts    = 0;
  int n_clamped    = 0;
  int n_overflow   = 0;
  int n_checked    = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  can_signal_packer_top #(
    .FRAME_BYTES(FRAME_BYTES),
    .FRAC_BITS  (FRAC_BITS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // scale one signal and merge it into the mirrored frame
  function automatic frame_t pack_signal(input req_t r);
    frame_t      f;
    longint      num;
    logic        neg;
    logic [63:0] mag;
    logic [63:0] divisor;
    logic [63:0] raw;
    int unsigned width;
    int unsigned pos;
    int unsigned i;
    f = '0;
    if (r.cmd == CMD_START) begin
      packed_payload = '0;
      latched_id     = r.msg_id;
      latched_len    = (r.data_len > FRAME_BYTES) ? 4'(FRAME_BYTES) : r.data_len;
    end else begin
      num = longint'($signed(r.phys)) * (longint'(1) << FRAC_BITS)
            - longint'($signed(r.offset));
      neg = (num < 0);
      mag = neg ? 64'(-num) : 64'(num);
      divisor = (r.factor == '0) ? 64'd1 : {32'd0, r.factor};
      raw = mag / divisor;
      // a quotient that truncates to zero is not a clamp
      if (neg && raw != '0) begin
        raw = '0;
        f.clamp = 1'b1;
      end
      width = (r.sig_len > MAX_SIGNAL_BITS) ? MAX_SIGNAL_BITS : r.sig_len;
      f.ovf = ((raw >> width) != '0);
      if (r.byte_order == BO_INTEL) begin
        for (i = 0; i < width; i++)
          if (raw[i] && (r.sig_start + i) < FRAME_BYTES * BITS_PER_BYTE)
            packed_payload[r.sig_start + i] = 1'b1;
      end else begin
        // msb at the start position, sawtooth down through each byte
        pos = r.sig_start;
        for (i = 0; i < width && pos < PAYLOAD_BITS; i++) begin
          if (raw[width - 1 - i] && pos < FRAME_BYTES * BITS_PER_BYTE)
            packed_payload[pos] = 1'b1;
          if (pos % BITS_PER_BYTE == 0)
            pos += 2 * BITS_PER_BYTE - 1;
          else
            pos -= 1;
        end
      end
    end
    f.id   = latched_id;
    f.len  = latched_len;
    f.data = packed_payload;
    return f;
  endfunction

  function automatic req_t mk_req(input logic cmd, input logic [28:0] id,
                                  input logic [3:0] dl, input logic [5:0] sb,
                                  input logic [5:0] sl, input logic bo,
                                  input logic [31:0] phys, input logic [31:0] fac,
                                  input logic [31:0] off);
    req_t r;
    r.cmd        = cmd;
    r.msg_id     = id;
    r.data_len   = dl;
    r.sig_start  = sb;
    r.sig_len    = sl;
    r.byte_order = bo;
    r.phys       = phys;
    r.factor     = fac;
    r.offset     = off;
    return r;
  endfunction

  function automatic frame_t mk_frame(input logic [28:0] id, input logic [3:0] len,
                                      input logic [63:0] data, input logic ovf,
                                      input logic clamp);
    frame_t f;
    f.id    = id;
    f.len   = len;
    f.data  = data;
    f.ovf   = ovf;
    f.clamp = clamp;
    return f;
  endfunction

  task automatic add_row(input req_t r, input logic known, input frame_t want);
    row_t row;
    row.req   = r;
    row.known = known;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // random request; inserts are mostly shaped so the raw value fits the signal
  function automatic req_t random_request(input logic cmd, input bit noisy);
    req_t        r;
    logic [63:0] target;
    longint      scaled;
    int unsigned kind;
    r.cmd        = cmd;
    r.msg_id     = 29'($urandom);
    r.data_len   = 4'($urandom);
    r.sig_start  = 6'($urandom);
    r.sig_len    = 6'($urandom);
    r.byte_order = 1'($urandom);
    r.phys       = $urandom;
    r.factor     = $urandom;
    r.offset     = $urandom;
    if (cmd == CMD_START || noisy) return r;
    kind = $urandom_range(0, 9);
    r.sig_len = 6'($urandom_range(1, MAX_SIGNAL_BITS));
    if (kind < 6) begin
      case ($urandom_range(0, 4))
        0: r.factor = Q_ONE;
        1: r.factor = Q_ONE >> $urandom_range(1, 8);
        2: r.factor = Q_ONE << $urandom_range(1, 4);
        default: r.factor = $urandom_range(32'h100, 32'h40000);
      endcase
      r.offset = (kind < 3) ? '0 : 32'($urandom_range(0, 32'h200000)) - 32'h100000;
      target = {$urandom, $urandom} & ((64'd1 << r.sig_len) - 1);
      scaled = longint'(target) * longint'(r.factor) + longint'($signed(r.offset));
      r.phys = 32'(scaled >>> FRAC_BITS);
    end else if (kind == 6) begin
      // negative raw value
      r.factor = Q_ONE;
      r.offset = '0;
      r.phys   = -32'($urandom_range(1, 1000));
    end else if (kind == 7) begin
      // signal length zero or above 32
      r.sig_len = $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(33, 63));
      r.factor  = Q_ONE;
    end else if (kind == 8) begin
      r.factor = $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
    end
    return r;
  endfunction

  // drive one request; called and returns at a falling edge
  task automatic issue(input req_t r, input logic known, input frame_t want);
    int     gap;
    frame_t f;
    if (calm_left > 0) begin
      gap = 0;
      calm_left--;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 99) < 3) calm_left = $urandom_range(30, 80);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, r.offset, r.factor, r.phys, r.byte_order, r.sig_len,
                      r.sig_start, r.data_len, r.msg_id};
    s_axis_tuser  <= r.cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    f = pack_signal(r);
    pending_frames.push_back(known ? want : f);
    requests_sent++;
    if (r.cmd == CMD_START) n_starts++;
    else n_inserts++;
    if (f.clamp) n_clamped++;
    if (f.ovf) n_overflow++;
    @(negedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_frames.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
      end else begin
        want_frame = pending_frames.pop_front();
        got_frame.id    = m_axis_tdata[28:0];
        got_frame.len   = m_axis_tdata[32:29];
        got_frame.data  = m_axis_tdata[96:33];
        got_frame.ovf   = m_axis_tdata[97];
        got_frame.clamp = m_axis_tdata[98];
        check_field("frame_id", 64'(want_frame.id), 64'(got_frame.id));
        check_field("frame_length", 64'(want_frame.len), 64'(got_frame.len));
        check_field("frame_data", want_frame.data, got_frame.data);
        check_field("value_overflow", 64'(want_frame.ovf), 64'(got_frame.ovf));
        check_field("value_clamped", 64'(want_frame.clamp), 64'(got_frame.clamp));
        n_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_frames.size());
      $display("can_signal_packer_top regression: fail");
      $finish;
    end
  end

  // result side backpressure: ready runs and stalls of random length
  initial begin
    int run;
    int stall;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      run = ($urandom_range(0, 99) < 5) ? $urandom_range(100, 300) : $urandom_range(1, 8);
      repeat (run) @(negedge clk_i);
      stall = pick_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
    end
  end

  // stimulus
  initial begin
    int roll;
    int k;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    packed_payload = '0;
    latched_id     = '0;
    latched_len    = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // insert before any start works on the reset frame
    add_row(mk_req(CMD_INSERT, 0, 0, 0, 4, BO_INTEL, 5, Q_ONE, 0), 1'b1,
            mk_frame(0, 0, 64'h5, 1'b0, 1'b0));
    // largest id, length saturates to the frame size
    add_row(mk_req(CMD_START, 29'h1FFF_FFFF, 4'hF, 0, 0, BO_MOTOROLA, 0, 0, 0), 1'b1,
            mk_frame(29'h1FFF_FFFF, 8, 64'h0, 1'b0, 1'b0));
    add_row(mk_req(CMD_INSERT, 0, 0, 0, 8, BO_INTEL, 32'hFF, Q_ONE, 0), 1'b1,
            mk_frame(29'h1FFF_FFFF, 8, 64'hFF, 1'b0, 1'b0));
    // raw wider than the signal is truncated
    add_row(mk_req(CMD_INSERT, 0, 0, 56, 8, BO_INTEL, 32'h1AB, Q_ONE, 0), 1'b1,
            mk_frame(29'h1FFF_FFFF, 8, 64'hAB00_0000_0000_00FF, 1'b1, 1'b0));
    // negative raw clamps to zero
    add_row(mk_req(CMD_INSERT, 0, 0, 8, 8, BO_INTEL, 32'hFFFF_FFFF, Q_ONE, 0), 1'b1,
            mk_frame(29'h1FFF_FFFF, 8, 64'hAB00_0000_0000_00FF, 1'b0, 1'b1));
    add_row(mk_req(CMD_START, 0, 0, 0, 0, BO_MOTOROLA, 0, 0, 0), 1'b1,
            mk_frame(0, 0, 64'h0, 1'b0, 1'b0));
    add_row(mk_req(CMD_INSERT, 0, 0, 7, 8, BO_MOTOROLA, 32'hA5, Q_ONE, 0), 1'b1,
            mk_frame(0, 0, 64'hA5, 1'b0, 1'b0));
    // motorola wraps from bit 0 to bit 7 of the next byte
    add_row(mk_req(CMD_INSERT, 0, 0, 0, 2, BO_MOTOROLA, 32'h3, Q_ONE, 0), 1'b1,
            mk_frame(0, 0, 64'h80A5, 1'b0, 1'b0));
    add_row(mk_req(CMD_START, 29'h123, 4'h8, 0, 0, BO_INTEL, 0, 0, 0), 1'b1,
            mk_frame(29'h123, 8, 64'h0, 1'b0, 1'b0));
    // bits running past the last byte are dropped
    add_row(mk_req(CMD_INSERT, 0, 0, 63, 16, BO_MOTOROLA, 32'hFFFF, Q_ONE, 0), 1'b0, '0);
    add_row(mk_req(CMD_INSERT, 0, 0, 60, 32, BO_INTEL, 32'hFFFF, Q_ONE, 0), 1'b0, '0);
    // small negative quotient truncates to zero without a clamp
    add_row(mk_req(CMD_INSERT, 0, 0, 16, 8, BO_INTEL, 0, Q_ONE, 1), 1'b0, '0);
    // zero factor acts as one
    add_row(mk_req(CMD_INSERT, 0, 0, 0, 16, BO_INTEL, 1, 0, 0), 1'b0, '0);
    // signal length zero and above 32
    add_row(mk_req(CMD_INSERT, 0, 0, 24, 0, BO_INTEL, 3, Q_ONE, 0), 1'b0, '0);
    add_row(mk_req(CMD_INSERT, 0, 0, 31, 63, BO_MOTOROLA, 32'h7FFF_FFFF, Q_ONE, 0),
            1'b0, '0);
    add_row(mk_req(CMD_START, 29'h0AAA_AAAA, 4'h9, 0, 0, BO_INTEL, 0, 0, 0), 1'b0, '0);
    // extremes of the scaling fields
    add_row(mk_req(CMD_INSERT, 0, 0, 0, 32, BO_INTEL, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                   32'h8000_0000), 1'b0, '0);
    add_row(mk_req(CMD_INSERT, 0, 0, 7, 32, BO_MOTOROLA, 32'h8000_0000, 32'h1,
                   32'h7FFF_FFFF), 1'b0, '0);
    add_row(mk_req(CMD_INSERT, 0, 0, 32, 16, BO_INTEL, 32'h8000_0000, 32'hFFFF_FFFF,
                   32'h8000_0000), 1'b0, '0);
    add_row(mk_req(CMD_INSERT, 0, 0, 39, 32, BO_MOTOROLA, 32'h1234_5678, Q_ONE, 0),
            1'b0, '0);
    // fractional factor and offset
    add_row(mk_req(CMD_INSERT, 0, 0, 40, 12, BO_INTEL, 100, 32'h8000, 32'h0001_8000),
            1'b0, '0);
    add_row(mk_req(CMD_START, 29'h1555_5555, 4'h4, 0, 0, BO_INTEL, 0, 0, 0), 1'b0, '0);
    add_row(mk_req(CMD_INSERT, 0, 0, 5, 1, BO_MOTOROLA, 1, Q_ONE, 0), 1'b0, '0);
    add_row(mk_req(CMD_INSERT, 0, 0, 63, 1, BO_INTEL, 1, Q_ONE, 0), 1'b0, '0);

    for (k = 0; k < directed_rows.size(); k++)
      issue(directed_rows[k].req, directed_rows[k].known, directed_rows[k].want);

    // random part: mostly whole frames, some noise and headless inserts
    while (requests_sent < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        issue(random_request(CMD_START, 1'b0), 1'b0, '0);
        repeat ($urandom_range(1, 7)) issue(random_request(CMD_INSERT, 1'b0), 1'b0, '0);
      end else if (roll < 90) begin
        issue(random_request(1'($urandom), 1'b1), 1'b0, '0);
      end else begin
        repeat ($urandom_range(1, 3)) issue(random_request(CMD_INSERT, 1'b0), 1'b0, '0);
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain outstanding results, then watch for strays
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d start and %0d insert requests (%0d clamped, %0d truncated)",
             n_starts, n_inserts, n_clamped, n_overflow);
    $display("checked %0d frames, %0d mismatches", n_checked, mismatches);
    if (mismatches == 0)
      $display("can_signal_packer_top regression: pass");
    else
      $display("can_signal_packer_top regression: fail");
    $finish;
  end

endmodule

// File: can_signal_packer_top.f
rtl/core/csp_pkg.sv
rtl/core/can_signal_packer_top.sv
sim/tb_top.sv
